### rtl/sle_pkg.sv
// ----------------------------------------------------------------------------
// Sorted list engine package
// Shared types, codes and sizes for the sorted list engine and its cells.
// ----------------------------------------------------------------------------
package sle_pkg;

  // Number of entries the store can hold.
  localparam int unsigned Capacity = 16;

  // Width of the entry count, which must be able to hold Capacity itself.
  localparam int unsigned CntW = $clog2(Capacity + 1);

  // Width of one stored value.
  localparam int unsigned ValW = 32;

  // Operation codes carried by a request.
  typedef enum logic [1:0] {
    SLE_OP_INSERT = 2'd0,
    SLE_OP_DELETE = 2'd1,
    SLE_OP_SEARCH = 2'd2
  } sle_op_e;

  // Status codes returned with every result.
  typedef enum logic [1:0] {
    SLE_ST_OK        = 2'd0,
    SLE_ST_NOT_FOUND = 2'd1,
    SLE_ST_FULL      = 2'd2
  } sle_status_e;

  // One request as it arrives on the input channel.
  typedef struct packed {
    logic [1:0]             opcode;
    logic signed [ValW-1:0] value;
  } sle_req_t;

  // One result as it leaves on the output channel.
  typedef struct packed {
    logic [1:0]      status;
    logic [CntW-1:0] count;
  } sle_rsp_t;

  // Shift commands broadcast to every cell of the chain.
  typedef struct packed {
    logic ins_en;
    logic del_en;
  } sle_ctl_t;

endpackage

### rtl/sorted_list_engine.sv
// ----------------------------------------------------------------------------
// Sorted list engine
// Keeps up to Capacity signed values in ascending order in a chain of cells
// and answers insert, delete and search requests.
// ----------------------------------------------------------------------------
// Usage:
//   A request (opcode and value) is taken on in_req_i at a rising edge where
//   in_valid_i is high and in_stall_o is low. Every request gives exactly one
//   result on out_rsp_o: a status and the entry count after the operation.
//   The result appears in out_valid_o on the cycle after the request is taken.
//   Throughput is one request per cycle while no result is stalled, set by
//   the single compare-and-shift step that every cell performs in parallel.
//   The result register holds its value while out_stall_i is high; during
//   that time in_stall_o is raised, so no new request is taken until the
//   waiting result has been taken, which may happen in the same cycle.
//   Insert into a full store and delete of an absent value leave the store
//   unchanged. Opcode 3 changes nothing and answers not found.
//   Reset clears the entry count and the result valid flag; the cells keep
//   whatever they held, which is never read before it is written.
// ----------------------------------------------------------------------------
module sorted_list_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  sle_pkg::sle_req_t in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output sle_pkg::sle_rsp_t out_rsp_o
);
  import sle_pkg::*;

  logic                   accept;
  logic [CntW-1:0]        count_q;
  logic [CntW-1:0]        count_d;
  logic                   out_valid_q;
  logic                   out_valid_d;
  sle_rsp_t               rsp_q;
  sle_rsp_t               rsp_d;
  sle_ctl_t               ctl;
  logic                   full;
  logic                   found;

  logic signed [ValW-1:0] cell_value [Capacity];
  logic [Capacity-1:0]    cell_gt;
  logic [Capacity-1:0]    cell_match;
  logic [Capacity-1:0]    occupied;
  logic [Capacity-1:0]    at_end;

  // Handshake: hold off requests while a result waits downstream.
  assign in_stall_o  = out_valid_q && out_stall_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

  assign full  = (count_q == CntW'(Capacity));
  assign found = |cell_match;

  // Cell chain.
  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    logic signed [ValW-1:0] left_value;
    logic                   left_gt;
    logic signed [ValW-1:0] right_value;

    assign occupied[i] = (count_q > CntW'(i));
    assign at_end[i]   = (count_q == CntW'(i));

    if (i == 0) begin : g_first
      assign left_value = '0;
      assign left_gt    = 1'b0;
    end else begin : g_inner_left
      assign left_value = cell_value[i-1];
      assign left_gt    = cell_gt[i-1];
    end

    if (i == Capacity - 1) begin : g_last
      assign right_value = '0;
    end else begin : g_inner_right
      assign right_value = cell_value[i+1];
    end

    sle_cell u_cell (
      .clk_i        (clk_i),
      .ctl_i        (ctl),
      .key_i        (in_req_i.value),
      .occupied_i   (occupied[i]),
      .at_end_i     (at_end[i]),
      .left_value_i (left_value),
      .left_gt_i    (left_gt),
      .right_value_i(right_value),
      .value_o      (cell_value[i]),
      .gt_o         (cell_gt[i]),
      .match_o      (cell_match[i])
    );
  end

  // Decode the request into shift commands, the new count and the result.
  always_comb begin
    ctl         = '0;
    count_d     = count_q;
    rsp_d       = rsp_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (accept) begin
      out_valid_d  = 1'b1;
      rsp_d.status = SLE_ST_NOT_FOUND;
      case (in_req_i.opcode)
        SLE_OP_INSERT: begin
          if (full) begin
            rsp_d.status = SLE_ST_FULL;
          end else begin
            ctl.ins_en   = 1'b1;
            count_d      = count_q + CntW'(1);
            rsp_d.status = SLE_ST_OK;
          end
        end
        SLE_OP_DELETE: begin
          if (found) begin
            ctl.del_en   = 1'b1;
            count_d      = count_q - CntW'(1);
            rsp_d.status = SLE_ST_OK;
          end
        end
        SLE_OP_SEARCH: begin
          if (found) begin
            rsp_d.status = SLE_ST_OK;
          end
        end
        default: begin
          rsp_d.status = SLE_ST_NOT_FOUND;
        end
      endcase
      rsp_d.count = count_d;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

endmodule

### rtl/sle_cell.sv
// ----------------------------------------------------------------------------
// Sorted list cell
// Holds one entry of the ascending list, compares it against the key of the
// current request and takes its value from a neighbour when the list shifts.
// ----------------------------------------------------------------------------
module sle_cell (
  input  logic                           clk_i,
  input  sle_pkg::sle_ctl_t              ctl_i,
  input  logic signed [sle_pkg::ValW-1:0] key_i,
  input  logic                           occupied_i,
  input  logic                           at_end_i,
  input  logic signed [sle_pkg::ValW-1:0] left_value_i,
  input  logic                           left_gt_i,
  input  logic signed [sle_pkg::ValW-1:0] right_value_i,
  output logic signed [sle_pkg::ValW-1:0] value_o,
  output logic                           gt_o,
  output logic                           match_o
);
  import sle_pkg::*;

  logic signed [ValW-1:0] value_q;
  logic signed [ValW-1:0] value_d;
  logic                   ge;

  // Compare the held entry with the key; an empty cell reports nothing.
  assign gt_o    = occupied_i && (value_q > key_i);
  assign ge      = occupied_i && (value_q >= key_i);
  assign match_o = occupied_i && (value_q == key_i);
  assign value_o = value_q;

  // Insert opens a gap at the first greater entry and shifts the rest right;
  // delete closes the gap from the first equal entry onwards.
  always_comb begin
    value_d = value_q;
    if (ctl_i.ins_en && (gt_o || at_end_i)) begin
      value_d = left_gt_i ? left_value_i : key_i;
    end else if (ctl_i.del_en && ge) begin
      value_d = right_value_i;
    end
  end

  // Entry storage needs no reset: only cells below the count are ever read.
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

### rtl/sle_checker.sv
// ----------------------------------------------------------------------------
// Sorted list engine checker
// Watches the ports of the sorted list engine and flags results that break
// the request and result ordering or the limits of the store.
// ----------------------------------------------------------------------------
module sle_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input sle_pkg::sle_rsp_t out_rsp_o
);
  import sle_pkg::*;

  // A stalled result stays valid and unchanged.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("stalled result changed or vanished");

  // Every request taken gives a result on the next cycle.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("request taken without a result on the next cycle");

  // A fresh result must have been caused by a request.
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !$past(out_valid_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("result appeared without a request");

  // The count never exceeds the capacity.
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_rsp_o.count <= CntW'(Capacity))
    else $error("entry count beyond capacity");

  // A full report only comes with a full store.
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.status == SLE_ST_FULL |-> out_rsp_o.count == CntW'(Capacity))
    else $error("full status with a store that is not full");

endmodule

bind sorted_list_engine sle_checker u_sle_checker (.*);
